>>> src/ffbsm_pkg.sv
// Package for the force-feedback effect slot manager.
// Holds report ids, effect kinds, load status codes and controller types.
package ffbsm_pkg;

    localparam logic [7:0] OP_EFFECT    = 8'h11;
    localparam logic [7:0] OP_CONSTANT  = 8'h12;
    localparam logic [7:0] OP_CONDITION = 8'h13;
    localparam logic [7:0] OP_OPERATION = 8'h14;
    localparam logic [7:0] OP_CONTROL   = 8'h15;
    localparam logic [7:0] OP_GAIN      = 8'h16;
    localparam logic [7:0] OP_CREATE    = 8'h17;
    localparam logic [7:0] OP_FREE      = 8'h1A;

    localparam logic [7:0] KIND_CONSTANT = 8'd1;
    localparam logic [7:0] KIND_SPRING   = 8'd8;
    localparam logic [7:0] KIND_DAMPER   = 8'd9;
    localparam logic [7:0] KIND_FRICTION = 8'd11;

    localparam logic [7:0] OPER_START = 8'd1;
    localparam logic [7:0] OPER_SOLO  = 8'd2;
    localparam logic [7:0] OPER_STOP  = 8'd3;

    localparam logic [7:0] CTL_ENABLE   = 8'd1;
    localparam logic [7:0] CTL_DISABLE  = 8'd2;
    localparam logic [7:0] CTL_STOP_ALL = 8'd3;
    localparam logic [7:0] CTL_RESET    = 8'd4;
    localparam logic [7:0] CTL_PAUSE    = 8'd5;
    localparam logic [7:0] CTL_CONTINUE = 8'd6;

    localparam logic [1:0] LOAD_SUCCESS = 2'd0;
    localparam logic [1:0] LOAD_FULL    = 2'd1;
    localparam logic [1:0] LOAD_ERROR   = 2'd2;

    localparam logic [7:0] GAIN_FULL = 8'd255;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_DONE = 3'b100
    } ctl_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic present;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic ignore;
    } dp_status_t;

    function automatic logic [7:0] packed_size(input logic [7:0] op);
        logic [7:0] sz;
        sz = 8'd0;
        unique case (op)
            OP_EFFECT:    sz = 8'd13;
            OP_CONSTANT:  sz = 8'd3;
            OP_CONDITION: sz = 8'd14;
            OP_OPERATION: sz = 8'd3;
            OP_CONTROL:   sz = 8'd1;
            OP_GAIN:      sz = 8'd1;
            OP_CREATE:    sz = 8'd3;
            OP_FREE:      sz = 8'd1;
            default:      sz = 8'd0;
        endcase
        return sz;
    endfunction

    function automatic logic kind_supported(input logic [7:0] k);
        return (k == KIND_CONSTANT) || (k == KIND_SPRING) ||
               (k == KIND_DAMPER) || (k == KIND_FRICTION);
    endfunction

endpackage

>>> src/ffbsm_ctrl.sv
// Controller state machine for the effect slot manager.
// Uses ffbsm_pkg for state and command types.
module ffbsm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ffbsm_pkg::dp_cmd_t    cmd,
    input  ffbsm_pkg::dp_status_t status
);
    import ffbsm_pkg::*;

    ctl_state_t state_reg, state_next;

    // advance idle -> execute -> done
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_DONE;
            ST_DONE: if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_DONE);
    assign cmd.capture = in_ready && in_valid;
    assign cmd.execute = (state_reg == ST_EXEC) && !status.ignore;
    assign cmd.present = out_valid;

endmodule

>>> src/ffbsm_dp.sv
// Datapath: request register, slot table, device state and result fields.
// Uses ffbsm_pkg for opcodes, codes and helper functions.
module ffbsm_dp #(
    parameter int SLOT_COUNT     = 4,
    parameter int POOL_BYTES     = 4096,
    parameter int BYTES_PER_SLOT = 128
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ffbsm_pkg::dp_cmd_t    cmd,
    output ffbsm_pkg::dp_status_t status,
    input  logic [7:0]            opcode,
    input  logic [7:0]            payload_length,
    input  logic [7:0]            block_index,
    input  logic [7:0]            effect_kind,
    input  logic [7:0]            gain_value,
    input  logic signed [15:0]    force_magnitude,
    input  logic signed [15:0]    center_offset,
    input  logic signed [15:0]    positive_coef,
    input  logic signed [15:0]    negative_coef,
    input  logic [7:0]            axis_offset,
    input  logic [7:0]            command_code,
    output logic                  accepted,
    output logic [2:0]            loaded_index,
    output logic [1:0]            create_status,
    output logic [12:0]           pool_free,
    output logic [2:0]            active_effect,
    output logic                  any_running,
    output logic                  pause_active,
    output logic                  actuators_on,
    output logic [7:0]            device_gain,
    output logic [15:0]           report_count
);
    import ffbsm_pkg::*;

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);

    // request register
    logic [7:0]  op_reg, len_reg, idx_reg, kind_reg, gain_reg, axis_reg, code_reg;
    logic [15:0] mag_reg, cen_reg, pc_reg, nc_reg;

    // slot table
    logic [SLOT_COUNT-1:0] alloc_reg, conf_reg, run_reg;
    logic [SLOT_COUNT-1:0] alloc_next, conf_next, run_next;
    logic [7:0]  type_reg [SLOT_COUNT];
    logic [7:0]  sgain_reg [SLOT_COUNT];
    logic [15:0] smag_reg [SLOT_COUNT];
    logic [15:0] scen_reg [SLOT_COUNT];
    logic [15:0] spc_reg [SLOT_COUNT];
    logic [15:0] snc_reg [SLOT_COUNT];
    logic [7:0]  type_next [SLOT_COUNT];
    logic [7:0]  sgain_next [SLOT_COUNT];
    logic [15:0] smag_next [SLOT_COUNT];
    logic [15:0] scen_next [SLOT_COUNT];
    logic [15:0] spc_next [SLOT_COUNT];
    logic [15:0] snc_next [SLOT_COUNT];

    // device state
    logic        act_reg, act_next, pause_reg, pause_next, ok_reg, ok_next;
    logic [7:0]  ggain_reg, ggain_next;
    logic [2:0]  lidx_reg, lidx_next;
    logic [1:0]  lstat_reg, lstat_next;
    logic [15:0] rx_reg, rx_next;

    logic          idx_ok;
    logic [SW-1:0] sel;
    logic          have_free;
    logic [SW-1:0] free_sel;

    // hold request
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= opcode;
            len_reg  <= payload_length;
            idx_reg  <= block_index;
            kind_reg <= effect_kind;
            gain_reg <= gain_value;
            mag_reg  <= force_magnitude;
            cen_reg  <= center_offset;
            pc_reg   <= positive_coef;
            nc_reg   <= negative_coef;
            axis_reg <= axis_offset;
            code_reg <= command_code;
        end
    end

    assign status.ignore = (len_reg == 8'd0);
    assign idx_ok = (idx_reg != 8'd0) && ({24'd0, idx_reg} <= 32'(SLOT_COUNT));
    assign sel    = SW'(idx_reg - 8'd1);

    // lowest unallocated slot
    always_comb begin
        have_free = 1'b0;
        free_sel  = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!alloc_reg[i]) begin
                have_free = 1'b1;
                free_sel  = SW'(i);
            end
        end
    end

    // execute one report
    always_comb begin
        logic claim;
        logic [7:0] ckind;
        alloc_next = alloc_reg; conf_next = conf_reg; run_next = run_reg;
        type_next = type_reg; sgain_next = sgain_reg; smag_next = smag_reg;
        scen_next = scen_reg; spc_next = spc_reg; snc_next = snc_reg;
        act_next = act_reg; pause_next = pause_reg; ggain_next = ggain_reg;
        lidx_next = lidx_reg; lstat_next = lstat_reg;
        rx_next = rx_reg + 16'd1;
        ok_next = 1'b0;
        claim = 1'b0;
        ckind = KIND_CONSTANT;

        // implicit allocation first
        if (op_reg == OP_CONDITION) ckind = KIND_SPRING;
        if (op_reg == OP_EFFECT) ckind = kind_reg;
        if (len_reg == packed_size(op_reg) && idx_ok &&
            (op_reg == OP_CONSTANT || op_reg == OP_CONDITION || op_reg == OP_OPERATION ||
             (op_reg == OP_EFFECT && kind_supported(kind_reg)))) begin
            claim = 1'b1;
            if (!alloc_reg[sel]) begin
                alloc_next[sel] = 1'b1;
                conf_next[sel]  = 1'b0;
                run_next[sel]   = 1'b0;
                type_next[sel]  = ckind;
                sgain_next[sel] = GAIN_FULL;
            end
        end

        if (packed_size(op_reg) != 8'd0 && len_reg == packed_size(op_reg)) begin
            unique case (op_reg)
                OP_EFFECT: if (claim) begin
                    ok_next = 1'b1;
                    conf_next[sel]  = 1'b1;
                    type_next[sel]  = kind_reg;
                    sgain_next[sel] = (gain_reg == 8'd0) ? GAIN_FULL : gain_reg;
                    run_next[sel]   = 1'b1;
                end
                OP_CONSTANT: if (claim) begin
                    ok_next = 1'b1;
                    conf_next[sel] = 1'b1;
                    type_next[sel] = KIND_CONSTANT;
                    smag_next[sel] = mag_reg;
                    run_next[sel]  = 1'b1;
                end
                OP_CONDITION: if (claim && axis_reg == 8'd0) begin
                    ok_next = 1'b1;
                    conf_next[sel] = 1'b1;
                    scen_next[sel] = cen_reg;
                    spc_next[sel]  = pc_reg;
                    snc_next[sel]  = nc_reg;
                    run_next[sel]  = 1'b1;
                end
                OP_OPERATION: if (claim) begin
                    ok_next = 1'b1;
                    if (code_reg == OPER_STOP) begin
                        run_next[sel] = 1'b0;
                    end else if (code_reg == OPER_START || code_reg == OPER_SOLO) begin
                        if (code_reg == OPER_SOLO) run_next = '0;
                        run_next[sel] = conf_next[sel];
                    end
                end
                OP_CONTROL: begin
                    ok_next = 1'b1;
                    unique case (code_reg)
                        CTL_ENABLE:   begin act_next = 1'b1; pause_next = 1'b0; end
                        CTL_DISABLE:  begin act_next = 1'b0; run_next = '0; end
                        CTL_STOP_ALL: run_next = '0;
                        CTL_RESET: begin
                            alloc_next = '0; conf_next = '0; run_next = '0;
                            for (int i = 0; i < SLOT_COUNT; i++) begin
                                type_next[i] = '0; sgain_next[i] = '0; smag_next[i] = '0;
                                scen_next[i] = '0; spc_next[i] = '0; snc_next[i] = '0;
                            end
                            act_next = 1'b0; pause_next = 1'b0; ggain_next = GAIN_FULL;
                            lidx_next = '0; lstat_next = LOAD_SUCCESS; rx_next = '0;
                        end
                        CTL_PAUSE:    pause_next = 1'b1;
                        CTL_CONTINUE: pause_next = 1'b0;
                        default:      ok_next = 1'b0;
                    endcase
                end
                OP_GAIN: begin
                    ok_next = 1'b1;
                    ggain_next = gain_reg;
                end
                OP_CREATE: begin
                    ok_next = 1'b1;
                    lidx_next = '0;
                    lstat_next = LOAD_ERROR;
                    if (kind_supported(kind_reg)) begin
                        if (have_free) begin
                            alloc_next[free_sel] = 1'b1;
                            conf_next[free_sel]  = 1'b1;
                            run_next[free_sel]   = 1'b0;
                            type_next[free_sel]  = kind_reg;
                            sgain_next[free_sel] = GAIN_FULL;
                            smag_next[free_sel]  = '0;
                            scen_next[free_sel]  = '0;
                            spc_next[free_sel]   = '0;
                            snc_next[free_sel]   = '0;
                            lidx_next  = 3'(32'(free_sel) + 1);
                            lstat_next = LOAD_SUCCESS;
                        end else begin
                            lstat_next = LOAD_FULL;
                        end
                    end
                end
                OP_FREE: if (idx_ok && alloc_reg[sel]) begin
                    ok_next = 1'b1;
                    alloc_next[sel] = 1'b0; conf_next[sel] = 1'b0; run_next[sel] = 1'b0;
                    type_next[sel] = '0; sgain_next[sel] = '0; smag_next[sel] = '0;
                    scen_next[sel] = '0; spc_next[sel] = '0; snc_next[sel] = '0;
                end
                default: ok_next = 1'b0;
            endcase
        end
    end

    // commit state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alloc_reg <= '0; conf_reg <= '0; run_reg <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                type_reg[i] <= '0; sgain_reg[i] <= '0; smag_reg[i] <= '0;
                scen_reg[i] <= '0; spc_reg[i] <= '0; snc_reg[i] <= '0;
            end
            act_reg <= 1'b0; pause_reg <= 1'b0; ggain_reg <= GAIN_FULL;
            lidx_reg <= '0; lstat_reg <= LOAD_SUCCESS; rx_reg <= '0; ok_reg <= 1'b0;
        end else if (cmd.capture) begin
            ok_reg <= 1'b0;
        end else if (cmd.execute) begin
            alloc_reg <= alloc_next; conf_reg <= conf_next; run_reg <= run_next;
            type_reg <= type_next; sgain_reg <= sgain_next; smag_reg <= smag_next;
            scen_reg <= scen_next; spc_reg <= spc_next; snc_reg <= snc_next;
            act_reg <= act_next; pause_reg <= pause_next; ggain_reg <= ggain_next;
            lidx_reg <= lidx_next; lstat_reg <= lstat_next; rx_reg <= rx_next;
            ok_reg <= ok_next;
        end
    end

    // summarize table for the result
    always_comb begin
        logic [CW-1:0] used;
        logic [31:0]   bytes;
        used = '0;
        active_effect = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (run_reg[i]) active_effect = 3'(i + 1);
        end
        for (int i = 0; i < SLOT_COUNT; i++) used = used + CW'(alloc_reg[i]);
        bytes = 32'(used) * 32'(BYTES_PER_SLOT);
        if (bytes > 32'(POOL_BYTES)) bytes = 32'(POOL_BYTES);
        pool_free = 13'(32'(POOL_BYTES) - bytes);
    end

    assign any_running    = |run_reg;
    assign accepted       = ok_reg && cmd.present;
    assign loaded_index   = lidx_reg;
    assign create_status  = lstat_reg;
    assign pause_active   = pause_reg;
    assign actuators_on   = act_reg;
    assign device_gain    = ggain_reg;
    assign report_count   = rx_reg;

endmodule

>>> src/ffb_effect_slot_manager.sv
// Force-feedback effect slot manager, top level.
// A taken request passes from idle (takes) through execute to done, where m_valid shows it.
// A new request is taken only once the controller FSM is back in idle, after m_ready takes the result.
// Reset: synchronous active-low aresetn clears the slot table and flags, device gain to 255.
// Depends on ffbsm_pkg, ffbsm_ctrl and ffbsm_dp.
module ffb_effect_slot_manager #(
    parameter int SLOT_COUNT     = 4,
    parameter int POOL_BYTES     = 4096,
    parameter int BYTES_PER_SLOT = 128
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_opcode,
    input  logic [7:0]         s_payload_length,
    input  logic [7:0]         s_block_index,
    input  logic [7:0]         s_effect_kind,
    input  logic [7:0]         s_gain_value,
    input  logic signed [15:0] s_force_magnitude,
    input  logic signed [15:0] s_center_offset,
    input  logic signed [15:0] s_positive_coef,
    input  logic signed [15:0] s_negative_coef,
    input  logic [7:0]         s_axis_offset,
    input  logic [7:0]         s_command_code,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_accepted,
    output logic [2:0]         m_loaded_index,
    output logic [1:0]         m_create_status,
    output logic [12:0]        m_pool_free,
    output logic [2:0]         m_active_effect,
    output logic               m_any_running,
    output logic               m_pause_active,
    output logic               m_actuators_on,
    output logic [7:0]         m_device_gain,
    output logic [15:0]        m_report_count
);
    import ffbsm_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    ffbsm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .out_valid(m_valid), .out_ready(m_ready),
        .cmd(cmd), .status(status)
    );

    ffbsm_dp #(
        .SLOT_COUNT(SLOT_COUNT), .POOL_BYTES(POOL_BYTES),
        .BYTES_PER_SLOT(BYTES_PER_SLOT)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .opcode(s_opcode), .payload_length(s_payload_length),
        .block_index(s_block_index), .effect_kind(s_effect_kind),
        .gain_value(s_gain_value), .force_magnitude(s_force_magnitude),
        .center_offset(s_center_offset), .positive_coef(s_positive_coef),
        .negative_coef(s_negative_coef), .axis_offset(s_axis_offset),
        .command_code(s_command_code),
        .accepted(m_accepted), .loaded_index(m_loaded_index),
        .create_status(m_create_status), .pool_free(m_pool_free),
        .active_effect(m_active_effect), .any_running(m_any_running),
        .pause_active(m_pause_active), .actuators_on(m_actuators_on),
        .device_gain(m_device_gain), .report_count(m_report_count)
    );

`ifndef SYNTH
    // never ready while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready while result pending");
    // a taken request yields a result once it has passed the execute state
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> ##1 m_valid) else $error("result missing");
    // running flag agrees with active slot
    a_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_any_running == (m_active_effect != 3'd0)) else $error("active mismatch");
`endif

endmodule
